FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds in a cycle, cons must hold in the same cycle
`define TCCE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante holds in a cycle, cons must hold in the next one
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tcce_pkg.sv
// ---------------------------------------------------------------------------
// tcce_pkg
// Field widths, character and op codes, defaults and store control bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  localparam int OP_W     = 2;
  localparam int SCREEN_W = 2;
  localparam int CHAR_W   = 8;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;

  localparam int ROWS_DEF     = 25;
  localparam int COLS_DEF     = 80;
  localparam int SCREENS_DEF  = 3;
  localparam int TAB_STOP_DEF = 8;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;

  typedef struct packed {
    logic              cell_we;
    logic [CHAR_W-1:0] cell_wdata;
    logic              len_we;
    logic              row_clr;
    logic              screen_clr;
  } store_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/tcce_if.sv
// ---------------------------------------------------------------------------
// tcce channel interfaces
// Command channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface tcce_in_if
  import tcce_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [SCREEN_W-1:0] screen;
  logic [CHAR_W-1:0]   char_code;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;

  modport source (output valid, op, screen, char_code, row, col, input ready);
  modport sink   (input valid, op, screen, char_code, row, col, output ready);
endinterface

interface tcce_out_if
  import tcce_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  logic [COL_W-1:0]  line_length;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_line;
  logic              rejected;

  modport source (output valid, cell_char, line_length, cursor_column, cursor_line,
                  rejected, input ready);
  modport sink   (input valid, cell_char, line_length, cursor_column, cursor_line,
                  rejected, output ready);
endinterface

`default_nettype wire

FILE: rtl/tcce_addr_unit.sv
// ---------------------------------------------------------------------------
// tcce_addr_unit
// Two-stage address unit: ring wrap of the visible row, then row-length
// index and cell address.
// ---------------------------------------------------------------------------
`default_nettype none

module tcce_addr_unit
  import tcce_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLS    = COLS_DEF,
  parameter int SCREENS = SCREENS_DEF
) (
  input  logic                                     clk,
  input  logic [((SCREENS > 1) ? $clog2(SCREENS) : 1)-1:0] sidx,
  input  logic [$clog2(ROWS)-1:0]                  top,
  input  logic [$clog2(ROWS)-1:0]                  vis,
  input  logic [$clog2(COLS+1)-1:0]                col,
  output logic [$clog2(SCREENS*ROWS)-1:0]          lidx,
  output logic [$clog2(SCREENS*ROWS*COLS)-1:0]     caddr
);

  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLS+1);
  localparam int SIW = (SCREENS > 1) ? $clog2(SCREENS) : 1;
  localparam int LW  = $clog2(SCREENS*ROWS);
  localparam int CAW = $clog2(SCREENS*ROWS*COLS);

  logic [RW:0]    sum;
  logic [RW-1:0]  phys;
  logic [RW-1:0]  s1_phys;
  logic [SIW-1:0] s1_sidx;
  logic [CW-1:0]  s1_col;

  // both operands are below ROWS, so one subtract finishes the wrap
  assign sum  = {1'b0, top} + {1'b0, vis};
  assign phys = (sum >= (RW+1)'(ROWS)) ? RW'(sum - (RW+1)'(ROWS)) : RW'(sum);

  always_ff @(posedge clk) begin
    s1_phys <= phys;
    s1_sidx <= sidx;
    s1_col  <= col;
  end

  always_ff @(posedge clk) begin
    lidx  <= LW'(LW'(s1_sidx) * LW'(ROWS) + LW'(s1_phys));
    caddr <= CAW'(CAW'(s1_sidx) * CAW'(ROWS*COLS) + CAW'(s1_phys) * CAW'(COLS)
                  + CAW'(s1_col));
  end

endmodule

`default_nettype wire

FILE: rtl/tcce_store.sv
// ---------------------------------------------------------------------------
// tcce_store
// Cell memory, row-length memory and the row-length valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module tcce_store
  import tcce_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLS    = COLS_DEF,
  parameter int SCREENS = SCREENS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  store_ctl_t                               ctl,
  input  logic [$clog2(SCREENS*ROWS)-1:0]          lidx,
  input  logic [$clog2(SCREENS*ROWS*COLS)-1:0]     caddr,
  input  logic [((SCREENS > 1) ? $clog2(SCREENS) : 1)-1:0] clr_sidx,
  input  logic [$clog2(COLS+1)-1:0]                len_wdata,
  output logic [CHAR_W-1:0]                        cell_q,
  output logic [$clog2(COLS+1)-1:0]                len_q,
  output logic                                     len_vld
);

  localparam int CW = $clog2(COLS+1);
  localparam int LD = SCREENS*ROWS;
  localparam int CD = SCREENS*ROWS*COLS;

  logic [CHAR_W-1:0] cell_mem [CD];
  logic [CW-1:0]     len_mem  [LD];
  logic [LD-1:0]     vld_bits;

  always_ff @(posedge clk) begin
    if (ctl.cell_we) begin
      cell_mem[caddr] <= ctl.cell_wdata;
    end
    cell_q <= cell_mem[caddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.len_we) begin
      len_mem[lidx] <= len_wdata;
    end
    len_q <= len_mem[lidx];
  end

  // a row whose bit is low reads as length zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_bits <= '0;
    end else begin
      if (ctl.screen_clr) begin
        for (int i = 0; i < LD; i++) begin
          if ((i / ROWS) == int'(clr_sidx)) begin
            vld_bits[i] <= 1'b0;
          end
        end
      end
      if (ctl.row_clr) begin
        vld_bits[lidx] <= 1'b0;
      end
      if (ctl.len_we) begin
        vld_bits[lidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_vld <= vld_bits[lidx];
  end

endmodule

`default_nettype wire

FILE: rtl/text_console_cell_engine_core.sv
// ---------------------------------------------------------------------------
// text_console_cell_engine_core
// Multi-screen text console: character writes, screen clear, cell reads.
// ---------------------------------------------------------------------------
// One command item is taken at a time and gives one result item, and the next
// is taken only once the last result has moved into the output register. A
// clear, carriage return, ignored code or rejected screen, a read past the last
// row, a backspace at column zero and a newline that does not scroll go
// straight to the result. A printable character, each space of a tab, a
// backspace and a cell read use the two-stage shared address unit and the
// registered reads of the cell and row-length memories, which every cell access
// passes through in turn; a scrolling newline uses the address unit to clear the
// row it reuses, and a deferred wrap takes the newline step first. No clearing
// pass follows reset: row lengths carry valid bits, and cells are only read below
// a row's length. A result waits in an output register while the next item is taken.
`default_nettype none
`include "assert_macros.svh"

module text_console_cell_engine_core
  import tcce_pkg::*;
#(
  parameter int ROWS     = ROWS_DEF,
  parameter int COLS     = COLS_DEF,
  parameter int SCREENS  = SCREENS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tcce_in_if.sink   cmd,
  tcce_out_if.source res
);

  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLS+1);
  localparam int SIW = (SCREENS > 1) ? $clog2(SCREENS) : 1;
  localparam int LW  = $clog2(SCREENS*ROWS);
  localparam int CAW = $clog2(SCREENS*ROWS*COLS);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_PUT     = 10'b00_0000_0010,
    S_NEWLINE = 10'b00_0000_0100,
    S_ADDR1   = 10'b00_0000_1000,
    S_ADDR2   = 10'b00_0001_0000,
    S_SCROLL  = 10'b00_0010_0000,
    S_MEM     = 10'b00_0100_0000,
    S_UPDATE  = 10'b00_1000_0000,
    S_DONE    = 10'b01_0000_0000,
    S_SPARE   = 10'b10_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    K_PUT,
    K_NL,
    K_BS,
    K_READ
  } kind_t;

  state_t state, state_next;

  // per-screen cursor and ring pointer
  logic [CW-1:0] scr_col [SCREENS];
  logic [RW-1:0] scr_row [SCREENS];
  logic [RW-1:0] scr_top [SCREENS];

  // item context
  logic [SIW-1:0]    ctx_sidx;
  logic              ctx_rej;
  kind_t             ctx_kind;
  logic              ctx_tab;
  logic [CHAR_W-1:0] ctx_ch;
  logic [CW-1:0]     ctx_col;
  logic [RW-1:0]     ctx_row;
  logic [RW-1:0]     ctx_top;
  logic [ROW_W-1:0]  rd_row;
  logic [COL_W-1:0]  rd_col;
  logic [CHAR_W-1:0] res_cell;
  logic [CW-1:0]     res_len;
  logic              scrolling;

  // output register
  logic              out_valid;
  logic [CHAR_W-1:0] out_cell;
  logic [COL_W-1:0]  out_len;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_line;
  logic              out_rej;
  logic              load_out;

  logic              accept;
  logic              scr_ok;
  logic [SIW-1:0]    sidx_in;
  logic [CW-1:0]     col_in;
  logic              is_print;
  logic              is_tab;
  logic              read_row_ok;
  logic [CW-1:0]     col_inc;
  logic [CW-1:0]     len_cur;
  logic              read_hit;
  logic [COLS:0]     tab_stop_at;

  logic [RW-1:0]     au_vis;
  logic [CW-1:0]     au_col;
  logic [LW-1:0]     lidx;
  logic [CAW-1:0]    caddr;

  store_ctl_t        st_ctl;
  logic [CW-1:0]     st_len_wdata;
  logic [CHAR_W-1:0] st_cell;
  logic [CW-1:0]     st_len;
  logic              st_vld;

  assign accept      = cmd.valid && cmd.ready;
  assign cmd.ready   = (state == S_IDLE);
  assign scr_ok      = int'(cmd.screen) < SCREENS;
  assign sidx_in     = SIW'(cmd.screen);
  assign col_in      = scr_col[sidx_in];
  assign is_tab      = (cmd.char_code == CH_TAB);
  assign is_print    = (cmd.char_code >= CH_SPACE) && (cmd.char_code != CH_DEL);
  assign read_row_ok = int'(cmd.row) < ROWS;

  assign col_inc  = ctx_col + CW'(1);
  assign len_cur  = st_vld ? st_len : '0;
  assign read_hit = (int'(rd_col) < int'(len_cur)) && (int'(rd_col) < COLS);

  always_comb begin
    for (int i = 0; i <= COLS; i++) begin
      tab_stop_at[i] = ((i % TAB_STOP) == 0);
    end
  end

  // scrolling looks up the old top row: visible row zero
  assign au_vis = scrolling ? '0 : ((ctx_kind == K_READ) ? RW'(rd_row) : ctx_row);
  assign au_col = (ctx_kind == K_READ) ? CW'(rd_col) : ctx_col;

  tcce_addr_unit #(
    .ROWS    (ROWS),
    .COLS    (COLS),
    .SCREENS (SCREENS)
  ) u_addr (
    .clk   (clk),
    .sidx  (ctx_sidx),
    .top   (ctx_top),
    .vis   (au_vis),
    .col   (au_col),
    .lidx  (lidx),
    .caddr (caddr)
  );

  always_comb begin
    st_ctl.cell_we    = (state == S_MEM) && ((ctx_kind == K_PUT) || (ctx_kind == K_BS));
    st_ctl.cell_wdata = ctx_ch;
    st_ctl.len_we     = (state == S_UPDATE) &&
                        (((ctx_kind == K_PUT) && (len_cur < col_inc)) ||
                         ((ctx_kind == K_BS) && (len_cur > ctx_col)));
    st_ctl.row_clr    = (state == S_SCROLL);
    st_ctl.screen_clr = accept && scr_ok && (cmd.op == OP_CLEAR);
    st_len_wdata      = (ctx_kind == K_PUT) ? col_inc : ctx_col;
  end

  tcce_store #(
    .ROWS    (ROWS),
    .COLS    (COLS),
    .SCREENS (SCREENS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (st_ctl),
    .lidx      (lidx),
    .caddr     (caddr),
    .clr_sidx  (sidx_in),
    .len_wdata (st_len_wdata),
    .cell_q    (st_cell),
    .len_q     (st_len),
    .len_vld   (st_vld)
  );

  assign load_out = (state == S_DONE) && (!out_valid || res.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          if (!scr_ok) begin
            state_next = S_DONE;
          end else begin
            unique case (cmd.op)
              OP_WRITE: begin
                priority if (cmd.char_code == CH_NL) begin
                  state_next = S_NEWLINE;
                end else if (cmd.char_code == CH_BS) begin
                  state_next = (col_in != '0) ? S_ADDR1 : S_DONE;
                end else if (is_tab || is_print) begin
                  state_next = S_PUT;
                end else begin
                  state_next = S_DONE;
                end
              end
              OP_READ:  state_next = read_row_ok ? S_ADDR1 : S_DONE;
              OP_CLEAR: state_next = S_DONE;
              OP_NONE:  state_next = S_DONE;
              default:  state_next = S_DONE;
            endcase
          end
        end
      end
      S_PUT:     state_next = (ctx_col >= CW'(COLS)) ? S_NEWLINE : S_ADDR1;
      S_NEWLINE: begin
        if (ctx_row != RW'(ROWS-1)) begin
          state_next = (ctx_kind == K_NL) ? S_DONE : S_PUT;
        end else begin
          state_next = S_ADDR1;
        end
      end
      S_ADDR1:   state_next = S_ADDR2;
      S_ADDR2:   state_next = scrolling ? S_SCROLL : S_MEM;
      S_SCROLL:  state_next = (ctx_kind == K_NL) ? S_DONE : S_PUT;
      S_MEM:     state_next = S_UPDATE;
      S_UPDATE: begin
        if ((ctx_kind == K_PUT) && ctx_tab && !tab_stop_at[col_inc]) begin
          state_next = S_PUT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE:    state_next = load_out ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scrolling <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        scrolling <= 1'b0;
      end else if ((state == S_NEWLINE) && (ctx_row == RW'(ROWS-1))) begin
        scrolling <= 1'b1;
      end else if (state == S_SCROLL) begin
        scrolling <= 1'b0;
      end
    end
  end

  // context datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          ctx_sidx <= sidx_in;
          ctx_rej  <= !scr_ok;
          rd_row   <= cmd.row;
          rd_col   <= cmd.col;
          res_cell <= ((cmd.op == OP_READ) && !read_row_ok) ? CH_SPACE : '0;
          res_len  <= '0;
          ctx_tab  <= is_tab;
          ctx_ch   <= (is_tab || (cmd.char_code == CH_BS)) ? CH_SPACE : cmd.char_code;
          if (cmd.op == OP_READ) begin
            ctx_kind <= K_READ;
          end else if (cmd.char_code == CH_NL) begin
            ctx_kind <= K_NL;
          end else if (cmd.char_code == CH_BS) begin
            ctx_kind <= K_BS;
          end else begin
            ctx_kind <= K_PUT;
          end
          unique case (cmd.op)
            OP_WRITE: begin
              ctx_row <= scr_row[sidx_in];
              ctx_top <= scr_top[sidx_in];
              if (cmd.char_code == CH_CR) begin
                ctx_col <= '0;
              end else if ((cmd.char_code == CH_BS) && (col_in != '0)) begin
                ctx_col <= col_in - CW'(1);
              end else begin
                ctx_col <= col_in;
              end
            end
            OP_CLEAR: begin
              ctx_col <= '0;
              ctx_row <= '0;
              ctx_top <= '0;
            end
            OP_READ, OP_NONE: begin
              ctx_col <= col_in;
              ctx_row <= scr_row[sidx_in];
              ctx_top <= scr_top[sidx_in];
            end
            default: begin
              ctx_col <= col_in;
              ctx_row <= scr_row[sidx_in];
              ctx_top <= scr_top[sidx_in];
            end
          endcase
        end
      end
      S_NEWLINE: begin
        ctx_col <= '0;
        if (ctx_row != RW'(ROWS-1)) begin
          ctx_row <= ctx_row + RW'(1);
        end
      end
      S_SCROLL: begin
        ctx_top <= (ctx_top == RW'(ROWS-1)) ? '0 : ctx_top + RW'(1);
      end
      S_UPDATE: begin
        unique case (ctx_kind)
          K_PUT:  ctx_col <= col_inc;
          K_READ: begin
            res_len  <= len_cur;
            res_cell <= read_hit ? st_cell : CH_SPACE;
          end
          K_NL:   begin
          end
          K_BS:   begin
          end
          default: begin
          end
        endcase
      end
      S_PUT, S_ADDR1, S_ADDR2, S_MEM, S_DONE, S_SPARE: begin
      end
      default: begin
      end
    endcase
  end

  // screen state is committed when the result is loaded into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SCREENS; i++) begin
        scr_col[i] <= '0;
        scr_row[i] <= '0;
        scr_top[i] <= '0;
      end
    end else if (load_out && !ctx_rej) begin
      scr_col[ctx_sidx] <= ctx_col;
      scr_row[ctx_sidx] <= ctx_row;
      scr_top[ctx_sidx] <= ctx_top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rej  <= ctx_rej;
      out_cell <= ctx_rej ? '0 : res_cell;
      out_len  <= ctx_rej ? '0 : COL_W'(res_len);
      out_col  <= ctx_rej ? '0 : COL_W'(ctx_col);
      out_line <= ctx_rej ? '0 : ROW_W'(ctx_row);
    end
  end

  assign res.valid         = out_valid;
  assign res.cell_char     = out_cell;
  assign res.line_length   = out_len;
  assign res.cursor_column = out_col;
  assign res.cursor_line   = out_line;
  assign res.rejected      = out_rej;

  `TCCE_ASSERT_NEXT(a_rej_done, accept && !scr_ok, (state == S_DONE) && ctx_rej, "bad screen not sent straight to result")
  `TCCE_ASSERT_IMPL(a_out_from_done, $rose(res.valid), $past(state == S_DONE), "result loaded outside done state")
  `TCCE_ASSERT_IMPL(a_scroll_bottom, state == S_SCROLL, ctx_row == RW'(ROWS-1), "scroll with cursor off the bottom row")
  `TCCE_ASSERT_IMPL(a_col_range, (state != S_IDLE) && !ctx_rej, ctx_col <= CW'(COLS), "cursor column beyond row width")

endmodule

`default_nettype wire

FILE: bench/tb_text_console_cell_engine_core.sv
// ---------------------------------------------------------------------------
// tb_text_console_cell_engine_core
// Drives write, clear and read items into the console core and checks every
// result item against a shadow copy of the screens, cursors and row lengths.
// Directed items first, then mixed random text, tab and newline runs, reads
// and noise under three stall mixes on the command and result channels.
// ---------------------------------------------------------------------------
module tb_text_console_cell_engine_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tcce_pkg::*;

  localparam int NROWS    = ROWS_DEF;
  localparam int NCOLS    = COLS_DEF;
  localparam int NSCREENS = SCREENS_DEF;
  localparam int NTAB     = TAB_STOP_DEF;
  localparam int BAD_SCREEN = 3;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SCREEN_W-1:0] screen;
    logic [CHAR_W-1:0]   char_code;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
  } console_cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [COL_W-1:0]  line_length;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_line;
    logic              rejected;
  } cell_view_t;

  logic clk;
  logic rst;

  tcce_in_if  cmd_ch ();
  tcce_out_if res_ch ();

  text_console_cell_engine_core dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // shadow of the console state
  logic [CHAR_W-1:0] shadow_cells [NSCREENS][NROWS][NCOLS];
  int shadow_len [NSCREENS][NROWS];
  int shadow_col [NSCREENS];
  int shadow_row [NSCREENS];
  int shadow_top [NSCREENS];

  cell_view_t pending_views [$];

  int fault_count;
  int scroll_count;
  int wrap_count;
  int write_count;
  int clear_count;
  int read_count;
  int noop_count;
  int effective_items;
  int send_idle_pct;
  int recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d results outstanding", pending_views.size());
    $display("FAILURE");
    $finish;
  end

  task automatic report_fault(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fault_count++;
  endtask

  function automatic int phys_row(int s, int vis);
    return (shadow_top[s] + vis) % NROWS;
  endfunction

  function automatic void shadow_newline(int s);
    shadow_col[s] = 0;
    if (shadow_row[s] + 1 >= NROWS) begin
      shadow_top[s] = (shadow_top[s] + 1) % NROWS;
      shadow_len[s][phys_row(s, NROWS - 1)] = 0;
      shadow_row[s] = NROWS - 1;
      scroll_count++;
    end else begin
      shadow_row[s]++;
    end
  endfunction

  function automatic void shadow_put(int s, logic [CHAR_W-1:0] ch);
    int p;
    if (shadow_col[s] >= NCOLS) begin
      shadow_newline(s);
      wrap_count++;
    end
    p = phys_row(s, shadow_row[s]);
    shadow_cells[s][p][shadow_col[s]] = ch;
    shadow_col[s]++;
    if (shadow_len[s][p] < shadow_col[s]) shadow_len[s][p] = shadow_col[s];
  endfunction

  // applies one item to the shadow and returns the view the core should report
  function automatic cell_view_t console_after(console_cmd_t c);
    cell_view_t v;
    int s;
    int p;
    v = '0;
    s = int'(c.screen);
    if (s >= NSCREENS) begin
      v.rejected = 1'b1;
      return v;
    end
    case (c.op)
      OP_WRITE: begin
        if (c.char_code == CH_NL) begin
          shadow_newline(s);
        end else if (c.char_code == CH_CR) begin
          shadow_col[s] = 0;
        end else if (c.char_code == CH_BS) begin
          if (shadow_col[s] > 0) begin
            shadow_col[s]--;
            p = phys_row(s, shadow_row[s]);
            shadow_cells[s][p][shadow_col[s]] = CH_SPACE;
            if (shadow_len[s][p] > shadow_col[s]) shadow_len[s][p] = shadow_col[s];
          end
        end else if (c.char_code == CH_TAB) begin
          shadow_put(s, CH_SPACE);
          while (shadow_col[s] % NTAB != 0) shadow_put(s, CH_SPACE);
        end else if (c.char_code >= CH_SPACE && c.char_code != CH_DEL) begin
          shadow_put(s, c.char_code);
        end
      end
      OP_CLEAR: begin
        for (p = 0; p < NROWS; p++) shadow_len[s][p] = 0;
        shadow_col[s] = 0;
        shadow_row[s] = 0;
        shadow_top[s] = 0;
      end
      OP_READ: begin
        v.cell_char = CH_SPACE;
        if (c.row < NROWS) begin
          p = phys_row(s, int'(c.row));
          v.line_length = COL_W'(shadow_len[s][p]);
          if (c.col < shadow_len[s][p] && c.col < NCOLS) v.cell_char = shadow_cells[s][p][c.col];
        end
      end
      default: ;
    endcase
    v.cursor_column = COL_W'(shadow_col[s]);
    v.cursor_line   = ROW_W'(shadow_row[s]);
    return v;
  endfunction

  function automatic console_cmd_t random_cmd(logic [OP_W-1:0] op, int s);
    console_cmd_t c;
    c.op        = op;
    c.screen    = SCREEN_W'(s);
    c.char_code = CHAR_W'($urandom_range(255));
    c.row       = ROW_W'($urandom_range(31));
    c.col       = COL_W'($urandom_range(127));
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] random_text_char();
    int k;
    k = int'($urandom_range(99));
    if (k < 55) return CHAR_W'($urandom_range(126, 32));
    if (k < 68) return CHAR_W'($urandom_range(255, 128));
    if (k < 76) return CH_NL;
    if (k < 80) return CH_CR;
    if (k < 88) return CH_BS;
    if (k < 94) return CH_TAB;
    if (k < 97) return CH_DEL;
    return CHAR_W'($urandom_range(31, 0));
  endfunction

  task automatic send_item(console_cmd_t c);
    int gap;
    gap = 0;
    while (int'($urandom_range(99)) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.op        <= c.op;
    cmd_ch.screen    <= c.screen;
    cmd_ch.char_code <= c.char_code;
    cmd_ch.row       <= c.row;
    cmd_ch.col       <= c.col;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    pending_views.push_back(console_after(c));
    if (c.screen >= NSCREENS || c.op == OP_NONE) begin
      noop_count++;
    end else begin
      case (c.op)
        OP_WRITE: write_count++;
        OP_CLEAR: clear_count++;
        default:  read_count++;
      endcase
      // ignored control codes leave the screen untouched
      if (!(c.op == OP_WRITE && (c.char_code == CH_DEL ||
            (c.char_code < CH_SPACE && c.char_code != CH_NL && c.char_code != CH_CR &&
             c.char_code != CH_BS && c.char_code != CH_TAB))))
        effective_items++;
    end
  endtask

  task automatic write_char(int s, logic [CHAR_W-1:0] ch);
    console_cmd_t c;
    c = random_cmd(OP_WRITE, s);
    c.char_code = ch;
    send_item(c);
  endtask

  task automatic read_cell(int s, int row, int col);
    console_cmd_t c;
    c = random_cmd(OP_READ, s);
    c.row = ROW_W'(row);
    c.col = COL_W'(col);
    send_item(c);
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  // result side: random back-pressure, then compare against the oldest view
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_result
    cell_view_t got;
    cell_view_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.cell_char, res_ch.line_length, res_ch.cursor_column,
              res_ch.cursor_line, res_ch.rejected};
      if (pending_views.size() == 0) begin
        report_fault("result item with nothing outstanding");
      end else begin
        want = pending_views.pop_front();
        if (got.cell_char !== want.cell_char)
          report_fault($sformatf("cell_char %0h, want %0h", got.cell_char, want.cell_char));
        if (got.line_length !== want.line_length)
          report_fault($sformatf("line_length %0d, want %0d",
                                 got.line_length, want.line_length));
        if (got.cursor_column !== want.cursor_column)
          report_fault($sformatf("cursor_column %0d, want %0d",
                                 got.cursor_column, want.cursor_column));
        if (got.cursor_line !== want.cursor_line)
          report_fault($sformatf("cursor_line %0d, want %0d",
                                 got.cursor_line, want.cursor_line));
        if (got.rejected !== want.rejected)
          report_fault($sformatf("rejected %0b, want %0b", got.rejected, want.rejected));
      end
    end
  end

  task automatic test_printable_and_ignored();
    write_char(0, CH_SPACE);
    write_char(0, 8'd126);
    write_char(0, 8'd255);
    write_char(0, 8'd0);
    write_char(0, 8'd31);
    write_char(0, CH_DEL);
    read_cell(0, 0, 2);
  endtask

  task automatic test_backspace_and_return();
    write_char(0, CH_BS);
    write_char(0, CH_CR);
    write_char(0, CH_BS);   // already at column zero
  endtask

  task automatic test_reads_out_of_range();
    read_cell(0, 31, 127);
    read_cell(0, 0, 127);
  endtask

  task automatic test_rejected_and_unused_op();
    write_char(BAD_SCREEN, 8'h41);
    send_item(random_cmd(OP_NONE, 1));
  endtask

  task automatic test_clear();
    send_item(random_cmd(OP_CLEAR, 0));
    read_cell(0, 0, 0);
  endtask

  task automatic test_deferred_wrap();
    // ten tabs leave the cursor parked at the right margin
    repeat (NCOLS / NTAB) write_char(2, CH_TAB);
    write_char(2, 8'h5a);
    read_cell(2, 1, 0);
  endtask

  task automatic test_newline();
    write_char(1, CH_NL);
  endtask

  task automatic test_random_traffic(int target);
    int kind;
    int n;
    int s;
    int row;
    int col;
    console_cmd_t c;
    while (effective_items < target) begin
      kind = int'($urandom_range(99));
      s = ($urandom_range(19) == 0) ? BAD_SCREEN : int'($urandom_range(NSCREENS - 1));
      if (kind < 40) begin
        n = int'($urandom_range(30, 4));
        repeat (n) write_char(s, random_text_char());
      end else if (kind < 52) begin
        n = int'($urandom_range(12, 5));
        repeat (n) write_char(s, CH_TAB);
        write_char(s, random_text_char());
      end else if (kind < 62) begin
        n = int'($urandom_range(30, 20));
        repeat (n) write_char(s, CH_NL);
      end else if (kind < 86) begin
        n = int'($urandom_range(10, 3));
        repeat (n) begin
          row = ($urandom_range(99) < 85) ? int'($urandom_range(NROWS - 1)) :
                                            int'($urandom_range(31, NROWS));
          col = int'($urandom_range(127));
          if (s < NSCREENS && row < NROWS && $urandom_range(99) < 60 &&
              shadow_len[s][phys_row(s, row)] > 0)
            col = int'($urandom_range(shadow_len[s][phys_row(s, row)] - 1));
          read_cell(s, row, col);
        end
      end else if (kind < 91) begin
        send_item(random_cmd(OP_CLEAR, s));
      end else begin
        n = int'($urandom_range(3, 1));
        repeat (n) begin
          if ($urandom_range(1) == 0) c = random_cmd(OP_W'($urandom_range(3)), BAD_SCREEN);
          else c = random_cmd(OP_NONE, int'($urandom_range(3)));
          send_item(c);
        end
      end
      if ($urandom_range(49) == 0) pause_until_drained();
    end
  endtask

  initial begin : main_sequence
    int s;
    int r;
    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.op        = OP_WRITE;
    cmd_ch.screen    = '0;
    cmd_ch.char_code = '0;
    cmd_ch.row       = '0;
    cmd_ch.col       = '0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    fault_count      = 0;
    scroll_count     = 0;
    wrap_count       = 0;
    write_count      = 0;
    clear_count      = 0;
    read_count       = 0;
    noop_count       = 0;
    effective_items  = 0;
    for (s = 0; s < NSCREENS; s++) begin
      shadow_col[s] = 0;
      shadow_row[s] = 0;
      shadow_top[s] = 0;
      for (r = 0; r < NROWS; r++) shadow_len[s][r] = 0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 13;
    recv_idle_pct = 59;
    test_printable_and_ignored();
    test_backspace_and_return();
    test_reads_out_of_range();
    test_rejected_and_unused_op();
    test_clear();
    test_deferred_wrap();
    test_newline();
    test_random_traffic(240);
    pause_until_drained();

    send_idle_pct = 59;
    recv_idle_pct = 13;
    test_random_traffic(480);
    pause_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(720);

    pause_until_drained();
    repeat (20) @(posedge clk);
    if (pending_views.size() != 0)
      report_fault($sformatf("%0d results never arrived", pending_views.size()));

    $display("Ran %0d writes, %0d clears, %0d reads and %0d rejected or unused items",
             write_count, clear_count, read_count, noop_count);
    $display("with %0d scrolls and %0d deferred wraps under three stall mixes; %0d faults",
             scroll_count, wrap_count, fault_count);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
